/* rtl/smq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO package
// Command and status codes, field widths and the operation record that
// travels from the command front end to the storage back end.
// ----------------------------------------------------------------------------
package smq_pkg;

   localparam int CMD_W    = 2;
   localparam int QID_W    = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int REF_W    = 8;

   localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_REFERR = 2'd3;

   localparam logic [REF_W-1:0] REF_MAX = 8'd255;

   // Outcome of one command, as decided by the front end.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [REF_W-1:0]    ref_after;
      logic                mem_wr;
      logic                mem_rd;
   } smq_op_type;

endpackage

/* rtl/smq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO channels
// Valid/ready interfaces for the command channel and the result channel.
// ----------------------------------------------------------------------------
interface smq_req_if import smq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [QID_W-1:0]         queue_id;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output cmd, output queue_id, output push_value,
                   input ready);
   modport sink   (input valid, input cmd, input queue_id, input push_value,
                   output ready);
endinterface

interface smq_rsp_if import smq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] pop_value;
   logic [REF_W-1:0]         ref_after;

   modport source (output valid, output status, output pop_value, output ref_after,
                   input ready);
   modport sink   (input valid, input status, input pop_value, input ref_after,
                   output ready);
endinterface

/* rtl/smq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO command front end
// Accepts command beats, keeps the per-queue head, fill and reference
// count, decides each command's outcome and storage access at once.
// ----------------------------------------------------------------------------
module smq_front import smq_pkg::*; #(
   parameter int NUM_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 128,
   parameter int QW          = 4,
   parameter int AW          = 7,
   parameter int ADDR_W      = 11
) (
   input  logic               clock,
   input  logic               reset,
   smq_req_if.sink            req_ch,
   input  logic               opq_full,
   output logic               opq_push,
   output smq_op_type         opq_op,
   output logic [ADDR_W-1:0]  opq_addr,
   output logic [DATA_W-1:0]  opq_data
);

   localparam logic [AW:0] DEPTH_F = (AW+1)'(QUEUE_DEPTH);

   logic [AW-1:0]    head_ff [NUM_QUEUES];
   logic [AW:0]      fill_ff [NUM_QUEUES];
   logic [REF_W-1:0] ref_ff  [NUM_QUEUES];

   logic             accept;
   logic             in_range;
   logic [QW-1:0]    q;
   logic [AW-1:0]    cur_head;
   logic [AW:0]      cur_fill;
   logic [REF_W-1:0] cur_ref;
   logic [AW:0]      tail_sum;
   logic [AW:0]      head_sum;
   logic [AW-1:0]    tail_idx;
   logic [AW-1:0]    head_inc;
   logic [AW-1:0]    head_in;
   logic [AW:0]      fill_in;
   logic [REF_W-1:0] ref_in;
   logic [AW-1:0]    mem_idx;
   smq_op_type       op;

   assign req_ch.ready = !opq_full;
   assign accept       = req_ch.valid && !opq_full;
   assign in_range     = 32'(req_ch.queue_id) < 32'(NUM_QUEUES);
   assign q            = QW'(req_ch.queue_id);

   assign cur_head = head_ff[q];
   assign cur_fill = fill_ff[q];
   assign cur_ref  = ref_ff[q];

   // Sums stay below twice the depth, so one conditional subtract wraps them.
   assign tail_sum = (AW+1)'(cur_head) + cur_fill;
   assign head_sum = (AW+1)'(cur_head) + (AW+1)'(1);
   assign tail_idx = (tail_sum >= DEPTH_F) ? AW'(tail_sum - DEPTH_F) : AW'(tail_sum);
   assign head_inc = (head_sum >= DEPTH_F) ? '0 : AW'(head_sum);

   always_comb begin
      head_in       = cur_head;
      fill_in       = cur_fill;
      ref_in        = cur_ref;
      mem_idx       = cur_head;
      op.status     = ST_OK;
      op.mem_wr     = 1'b0;
      op.mem_rd     = 1'b0;
      case (req_ch.cmd)
         CMD_CREATE: begin
            if (cur_ref == REF_MAX) begin
               op.status = ST_REFERR;
            end else begin
               ref_in = cur_ref + REF_W'(1);
            end
         end
         CMD_PUSH: begin
            if (cur_fill == DEPTH_F) begin
               op.status = ST_FULL;
            end else begin
               op.mem_wr = 1'b1;
               mem_idx   = tail_idx;
               fill_in   = cur_fill + (AW+1)'(1);
            end
         end
         CMD_POP: begin
            if (cur_fill == '0) begin
               op.status = ST_EMPTY;
            end else begin
               op.mem_rd = 1'b1;
               head_in   = head_inc;
               fill_in   = cur_fill - (AW+1)'(1);
            end
         end
         CMD_DESTROY: begin
            if (cur_ref == '0) begin
               op.status = ST_REFERR;
            end else begin
               ref_in = cur_ref - REF_W'(1);
               // The last reference gone empties the queue.
               if (ref_in == '0) begin
                  head_in = '0;
                  fill_in = '0;
               end
            end
         end
         default: begin
            op.status = ST_OK;
         end
      endcase
      op.ref_after = ref_in;
      if (!in_range) begin
         op.status    = ST_OK;
         op.mem_wr    = 1'b0;
         op.mem_rd    = 1'b0;
         op.ref_after = '0;
      end
   end

   assign opq_push = accept;
   assign opq_op   = op;
   assign opq_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(mem_idx);
   assign opq_data = req_ch.push_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
            ref_ff[i]  <= '0;
         end
      end else if (accept && in_range) begin
         head_ff[q] <= head_in;
         fill_ff[q] <= fill_in;
         ref_ff[q]  <= ref_in;
      end
   end

endmodule

/* rtl/smq_opq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO operation queue
// Two-entry queue between the front end and the back end so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module smq_opq import smq_pkg::*; #(
   parameter int ADDR_W = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  smq_op_type         push_op,
   input  logic [ADDR_W-1:0]  push_addr,
   input  logic [DATA_W-1:0]  push_data,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop,
   output smq_op_type         pop_op,
   output logic [ADDR_W-1:0]  pop_addr,
   output logic [DATA_W-1:0]  pop_data
);

   localparam int ENTRIES = 2;

   smq_op_type        op_ff   [ENTRIES];
   logic [ADDR_W-1:0] addr_ff [ENTRIES];
   logic [DATA_W-1:0] data_ff [ENTRIES];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_pop;

   assign full      = count_ff == 2'(ENTRIES);
   assign pop_valid = count_ff != '0;
   assign do_pop    = pop && pop_valid;
   assign pop_op    = op_ff[rd_ptr_ff];
   assign pop_addr  = addr_ff[rd_ptr_ff];
   assign pop_data  = data_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= push_op;
         addr_ff[wr_ptr_ff] <= push_addr;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/smq_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO storage back end
// Carries out each operation on the entry memory and holds the result
// beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module smq_back import smq_pkg::*; #(
   parameter int ADDR_W    = 11,
   parameter int MEM_DEPTH = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   output logic               op_pop,
   input  smq_op_type         op,
   input  logic [ADDR_W-1:0]  op_addr,
   input  logic [DATA_W-1:0]  op_data,
   smq_rsp_if.source          rsp_ch
);

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              rsp_valid_ff;
   smq_op_type        rsp_op_ff;
   logic              issue;

   // An operation issues when the output register is empty or being emptied.
   assign issue  = op_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign op_pop = issue;

   always_ff @(posedge clock) begin
      if (issue && op.mem_wr) begin
         mem[op_addr] <= op_data;
      end
      if (issue && op.mem_rd) begin
         rd_data_ff <= mem[op_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (issue) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_op_ff <= op;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_op_ff.status;
   assign rsp_ch.ref_after = rsp_op_ff.ref_after;
   assign rsp_ch.pop_value = rsp_op_ff.mem_rd ? rd_data_ff : '0;

endmodule

/* rtl/shared_multi_queue_fifo.sv */
`timescale 1ns / 1ps
// A result beat turns valid once its command has passed through the operation
// queue into the back end's result register. Throughput: one command per cycle
// unless stalled results fill the queue; the single-port entry memory does one
// read or one write per command, and per-queue pointers live in flip-flops.
// Reset clears heads, fills and reference counts at once; the entry memory is
// not cleared, since only entries written by a push are ever read.
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO with reference counts
// Front end decides each command against per-queue state, a short queue
// decouples it from the back end that accesses the entry memory.
// ----------------------------------------------------------------------------
module shared_multi_queue_fifo import smq_pkg::*; #(
   parameter int NUM_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 128
) (
   input  logic      clock,
   input  logic      reset,
   smq_req_if.sink   req_ch,
   smq_rsp_if.source rsp_ch
);

   localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int AW        = $clog2(QUEUE_DEPTH);
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic              fq_push;
   smq_op_type        fq_op;
   logic [ADDR_W-1:0] fq_addr;
   logic [DATA_W-1:0] fq_data;
   logic              fq_full;
   logic              bq_valid;
   logic              bq_pop;
   smq_op_type        bq_op;
   logic [ADDR_W-1:0] bq_addr;
   logic [DATA_W-1:0] bq_data;

   smq_front #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .QW          (QW),
      .AW          (AW),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .opq_full (fq_full),
      .opq_push (fq_push),
      .opq_op   (fq_op),
      .opq_addr (fq_addr),
      .opq_data (fq_data)
   );

   smq_opq #(
      .ADDR_W (ADDR_W)
   ) u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_op   (fq_op),
      .push_addr (fq_addr),
      .push_data (fq_data),
      .full      (fq_full),
      .pop_valid (bq_valid),
      .pop       (bq_pop),
      .pop_op    (bq_op),
      .pop_addr  (bq_addr),
      .pop_data  (bq_data)
   );

   smq_back #(
      .ADDR_W    (ADDR_W),
      .MEM_DEPTH (MEM_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (bq_valid),
      .op_pop   (bq_pop),
      .op       (bq_op),
      .op_addr  (bq_addr),
      .op_data  (bq_data),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* rtl/smq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO port checker
// Watches the command and result ports and checks beat ordering and the
// consistency of result fields.
// ----------------------------------------------------------------------------
module smq_checker import smq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic signed [DATA_W-1:0] rsp_pop_value,
   input logic [REF_W-1:0]         rsp_ref_after
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No result beat appears without a command beat still owed one.
   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result beat without an outstanding command");

   // The design never holds more than three commands in flight.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("too many commands in flight");

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_pop_value) && $stable(rsp_ref_after))
      else $error("stalled result beat changed");

   // A failed command returns no value.
   a_err_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_pop_value == '0)
      else $error("failed command returned a value");

   // A reference count error leaves the count at one of its limits.
   a_referr_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_REFERR |->
         rsp_ref_after == '0 || rsp_ref_after == REF_MAX)
      else $error("reference count error away from a limit");

endmodule

bind shared_multi_queue_fifo smq_checker u_smq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_pop_value (rsp_ch.pop_value),
   .rsp_ref_after (rsp_ch.ref_after)
);

/* tb/sv/shared_multi_queue_fifo_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multi-queue FIFO testbench
// Drives command beats with random gaps and stalls the result channel at
// random. It keeps its own copy of the queue pointers, fills, reference
// counts and stored values, and compares every result beat field by field.
// Directed beats come first. Long runs then take one queue to its reference
// limit and another to full and around its wrap. Random traffic follows.
// ----------------------------------------------------------------------------
module shared_multi_queue_fifo_tb;
   import smq_pkg::*;

   localparam int NUM_Q       = 16;
   localparam int DEPTH       = 128;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_IDLE    = 13;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_style_type;

   typedef struct {
      logic [CMD_W-1:0]         cmd;
      logic [QID_W-1:0]         queue_id;
      logic signed [DATA_W-1:0] value;
      int unsigned              gap;
      int unsigned              stall;
      bit                       drain;
   } cmd_beat_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] pop_value;
      logic [REF_W-1:0]         ref_after;
      int unsigned              stall;
   } rsp_beat_type;

   logic clock;
   logic reset;

   smq_req_if req_ch ();
   smq_rsp_if rsp_ch ();

   shared_multi_queue_fifo #(
      .NUM_QUEUES  (NUM_Q),
      .QUEUE_DEPTH (DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cmd_beat_type   command_backlog[$];
   rsp_beat_type   pending_results[$];
   idle_style_type idle_mode;
   int unsigned    fail_count;
   int unsigned    cycle_count;
   int unsigned    wait_cycles;
   int unsigned    stall_left;
   int unsigned    beat_stall;
   bit             drained;
   rsp_beat_type   outcome;
   rsp_beat_type   oldest;

   // Mirror of the block's queue state.
   logic [6:0]               q_head    [NUM_Q];
   logic [7:0]               q_fill    [NUM_Q];
   logic [REF_W-1:0]         q_refs    [NUM_Q];
   logic signed [DATA_W-1:0] q_entries [NUM_Q*DEPTH];

   function automatic rsp_beat_type apply_queue_command(logic [CMD_W-1:0] cmd,
                                                        logic [QID_W-1:0] qid,
                                                        logic signed [DATA_W-1:0] value);
      rsp_beat_type r;
      logic [6:0]   tail;
      r.status    = ST_OK;
      r.pop_value = '0;
      r.stall     = 0;
      case (cmd)
         CMD_CREATE: begin
            if (q_refs[qid] == REF_MAX) r.status = ST_REFERR;
            else q_refs[qid] = q_refs[qid] + 1'b1;
         end
         CMD_PUSH: begin
            if (q_fill[qid] == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               tail = 7'(q_head[qid] + q_fill[qid]);
               q_entries[{qid, tail}] = value;
               q_fill[qid] = q_fill[qid] + 1'b1;
            end
         end
         CMD_POP: begin
            if (q_fill[qid] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.pop_value = q_entries[{qid, q_head[qid]}];
               q_head[qid] = q_head[qid] + 1'b1;
               q_fill[qid] = q_fill[qid] - 1'b1;
            end
         end
         CMD_DESTROY: begin
            if (q_refs[qid] == 0) begin
               r.status = ST_REFERR;
            end else begin
               q_refs[qid] = q_refs[qid] - 1'b1;
               // The last reference gone empties the queue.
               if (q_refs[qid] == 0) begin
                  q_head[qid] = '0;
                  q_fill[qid] = '0;
               end
            end
         end
         default: begin
            r.status = ST_OK;
         end
      endcase
      r.ref_after = q_refs[qid];
      return r;
   endfunction

   function automatic int unsigned draw_idle();
      case (idle_mode)
         IDLE_NONE:  return 0;
         IDLE_HEAVY: return $urandom_range(0, MAX_IDLE);
         default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_IDLE) : 0;
      endcase
   endfunction

   function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [QID_W-1:0] qid,
                                   logic signed [DATA_W-1:0] value, bit drain);
      cmd_beat_type b;
      b.cmd      = cmd;
      b.queue_id = qid;
      b.value    = value;
      b.gap      = draw_idle();
      b.stall    = draw_idle();
      b.drain    = drain;
      command_backlog.push_back(b);
   endfunction

   function automatic void add_random_cmd(logic [QID_W-1:0] qid, bit drain);
      int unsigned pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 15)      cmd = CMD_CREATE;
      else if (pick < 50) cmd = CMD_PUSH;
      else if (pick < 85) cmd = CMD_POP;
      else                cmd = CMD_DESTROY;
      add_cmd(cmd, qid, $urandom(), drain);
   endfunction

   // Unrelated traffic on the low queues, mixed into the long runs.
   function automatic void maybe_noise();
      if ($urandom_range(0, 4) == 0) add_random_cmd(4'($urandom_range(0, 11)), 1'b0);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Command driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         wait_cycles  <= 0;
         beat_stall   <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (command_backlog.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (wait_cycles < command_backlog[0].gap) begin
            req_ch.valid <= 1'b0;
            wait_cycles  <= wait_cycles + 1;
         end else if (command_backlog[0].drain && (req_ch.valid || !drained)) begin
            // Hold the next beat until every earlier result is back.
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid      <= 1'b1;
            req_ch.cmd        <= command_backlog[0].cmd;
            req_ch.queue_id   <= command_backlog[0].queue_id;
            req_ch.push_value <= command_backlog[0].value;
            beat_stall        <= command_backlog[0].stall;
            wait_cycles       <= 0;
            void'(command_backlog.pop_front());
         end
      end
   end

   // Result monitor: tracks accepted commands and checks result beats.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
         drained      <= 1'b1;
         for (int i = 0; i < NUM_Q; i++) begin
            q_head[i] = '0;
            q_fill[i] = '0;
            q_refs[i] = '0;
         end
         pending_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            outcome = apply_queue_command(req_ch.cmd, req_ch.queue_id, req_ch.push_value);
            outcome.stall = beat_stall;
            pending_results.push_back(outcome);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no command outstanding");
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_ch.status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.pop_value !== oldest.pop_value) begin
                  $error("pop_value: expected %0d, got %0d", oldest.pop_value,
                         rsp_ch.pop_value);
                  fail_count++;
               end
               if (rsp_ch.ref_after !== oldest.ref_after) begin
                  $error("ref_after: expected %0d, got %0d", oldest.ref_after,
                         rsp_ch.ref_after);
                  fail_count++;
               end
               rsp_ch.ready <= (oldest.stall == 0);
               stall_left   <= oldest.stall;
            end
         end else if (!rsp_ch.ready) begin
            if (stall_left <= 1) rsp_ch.ready <= 1'b1;
            stall_left <= stall_left - 1;
         end
         drained <= (pending_results.size() == 0);
      end
   end

   initial begin
      reset             = 1'b1;
      fail_count        = 0;
      cycle_count       = 0;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_CREATE;
      req_ch.queue_id   = '0;
      req_ch.push_value = '0;
      rsp_ch.ready      = 1'b0;

      // Directed: reference errors, empty pops, value extremes, no-reference use,
      // and a destroy that empties a queue holding data.
      idle_mode = IDLE_LIGHT;
      add_cmd(CMD_DESTROY, 4'd0, 32'sd0, 1'b0);
      add_cmd(CMD_POP,     4'd0, 32'sd0, 1'b0);
      add_cmd(CMD_CREATE,  4'd0, 32'sd0, 1'b0);
      add_cmd(CMD_PUSH,    4'd0, 32'h7FFF_FFFF, 1'b0);
      add_cmd(CMD_PUSH,    4'd0, 32'h8000_0000, 1'b0);
      add_cmd(CMD_PUSH,    4'd0, 32'hFFFF_FFFF, 1'b0);
      add_cmd(CMD_PUSH,    4'd0, 32'h0000_0000, 1'b0);
      repeat (4) add_cmd(CMD_POP, 4'd0, 32'sd0, 1'b0);
      add_cmd(CMD_POP,     4'd0, 32'sd0, 1'b0);
      add_cmd(CMD_PUSH,    4'd15, 32'h5555_AAAA, 1'b0);
      add_cmd(CMD_PUSH,    4'd15, 32'hAAAA_5555, 1'b0);
      add_cmd(CMD_POP,     4'd15, 32'sd0, 1'b0);
      add_cmd(CMD_CREATE,  4'd1, 32'sd0, 1'b0);
      add_cmd(CMD_PUSH,    4'd1, 32'h1234_5678, 1'b0);
      add_cmd(CMD_DESTROY, 4'd1, 32'sd0, 1'b0);
      add_cmd(CMD_POP,     4'd1, 32'sd0, 1'b0);
      add_cmd(CMD_PUSH,    4'd1, 32'hCAFE_F00D, 1'b0);
      add_cmd(CMD_POP,     4'd1, 32'sd0, 1'b0);
      add_cmd(CMD_DESTROY, 4'd0, 32'sd0, 1'b0);

      // Reference count up to its limit and one past it, with no idling.
      idle_mode = IDLE_NONE;
      add_cmd(CMD_CREATE, 4'd14, $urandom(), 1'b1);
      for (int i = 0; i < 255; i++) begin
         add_cmd(CMD_CREATE, 4'd14, $urandom(), 1'b0);
         maybe_noise();
      end
      for (int i = 0; i < 10; i++) begin
         add_cmd(CMD_DESTROY, 4'd14, $urandom(), 1'b0);
         maybe_noise();
      end

      // Fill a queue past full, then run its pointers around the wrap.
      idle_mode = IDLE_HEAVY;
      for (int i = 0; i < 129; i++) begin
         add_cmd(CMD_PUSH, 4'd13, $urandom(), i == 0);
         maybe_noise();
      end
      for (int i = 0; i < 30; i++) begin
         add_cmd(CMD_POP, 4'd13, $urandom(), 1'b0);
         maybe_noise();
      end
      for (int i = 0; i < 31; i++) begin
         add_cmd(CMD_PUSH, 4'd13, $urandom(), 1'b0);
         maybe_noise();
      end
      for (int i = 0; i < 129; i++) begin
         add_cmd(CMD_POP, 4'd13, $urandom(), 1'b0);
         maybe_noise();
      end

      // Random traffic, mostly on a few working queues.
      for (int i = 0; i < 300; i++) begin
         if (i % 100 == 0) idle_mode = idle_style_type'((i / 100) % 3);
         if ($urandom_range(0, 3) == 0)
            add_random_cmd(4'($urandom_range(0, NUM_Q - 1)), i % 100 == 0);
         else
            add_random_cmd(4'(2 + 4 * $urandom_range(0, 2)), i % 100 == 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (command_backlog.size() != 0 || req_ch.valid || pending_results.size() != 0)
         @(negedge clock);
      repeat (2 * MAX_IDLE) @(negedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/smq_pkg.sv
rtl/smq_if.sv
rtl/smq_front.sv
rtl/smq_opq.sv
rtl/smq_back.sv
rtl/shared_multi_queue_fifo.sv
rtl/smq_checker.sv
tb/sv/shared_multi_queue_fifo_tb.sv
